@@ hdl/ckwe_pkg.sv @@
// Shared types, constants and distance function for the chroma key window edge block.
package ckwe_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COMP_W    = 8;
  localparam int PIX_W     = 3 * COMP_W;
  localparam int DIST_W    = 10;
  localparam int FW_W      = 13;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_FIRST    = 3'd0,
    REG_TARGET_SECOND   = 3'd1,
    REG_TARGET_THIRD    = 3'd2,
    REG_THRESHOLD_LEVEL = 3'd3,
    REG_FRAME_WIDTH     = 3'd4
  } cfg_reg_t;

  // per-pixel control that rides along the window pipeline
  typedef struct packed {
    logic emit;   // pixel completes a window
    logic last;   // pixel sits in the last column of its row
  } win_ctl_t;

  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // sum of absolute component differences, 0..765
  function automatic logic [DIST_W-1:0] key_distance(input logic [PIX_W-1:0]  px,
                                                     input logic [COMP_W-1:0] ta,
                                                     input logic [COMP_W-1:0] tb,
                                                     input logic [COMP_W-1:0] tc);
    key_distance = DIST_W'(abs_diff(px[COMP_W-1:0], ta))
                 + DIST_W'(abs_diff(px[2*COMP_W-1:COMP_W], tb))
                 + DIST_W'(abs_diff(px[3*COMP_W-1:2*COMP_W], tc));
  endfunction

endpackage

@@ hdl/ckwe_line_buf.sv @@
// Single-port line buffer RAM, read-first, registered read data.
module ckwe_line_buf #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 24,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
      if (we) begin
        mem[addr] <= wdata;
      end
    end
  end

endmodule

@@ hdl/ckwe_edge_calc.sv @@
// Window distance register stage and min/max threshold edge logic.
module ckwe_edge_calc (
  input  logic                          clk,
  input  logic                          load,
  input  logic [ckwe_pkg::PIX_W-1:0]    upl_px,
  input  logic [ckwe_pkg::PIX_W-1:0]    up_px,
  input  logic [ckwe_pkg::PIX_W-1:0]    left_px,
  input  logic [ckwe_pkg::PIX_W-1:0]    cur_px,
  input  logic [ckwe_pkg::COMP_W-1:0]   target_first,
  input  logic [ckwe_pkg::COMP_W-1:0]   target_second,
  input  logic [ckwe_pkg::COMP_W-1:0]   target_third,
  input  logic [ckwe_pkg::DIST_W-1:0]   threshold_level,
  input  ckwe_pkg::win_ctl_t            ctl_in,
  output ckwe_pkg::win_ctl_t            ctl_out,
  output logic [ckwe_pkg::DIST_W-1:0]   edge_value
);

  logic [ckwe_pkg::DIST_W-1:0] key_dist [4];
  logic [ckwe_pkg::DIST_W-1:0] mx01, mn01, mx23, mn23, mx, mn;

  always_ff @(posedge clk) begin
    if (load) begin
      key_dist[0] <= ckwe_pkg::key_distance(upl_px, target_first, target_second, target_third);
      key_dist[1] <= ckwe_pkg::key_distance(up_px, target_first, target_second, target_third);
      key_dist[2] <= ckwe_pkg::key_distance(left_px, target_first, target_second, target_third);
      key_dist[3] <= ckwe_pkg::key_distance(cur_px, target_first, target_second, target_third);
      ctl_out <= ctl_in;
    end
  end

  always_comb begin
    mx01 = (key_dist[1] > key_dist[0]) ? key_dist[1] : key_dist[0];
    mn01 = (key_dist[1] < key_dist[0]) ? key_dist[1] : key_dist[0];
    mx23 = (key_dist[3] > key_dist[2]) ? key_dist[3] : key_dist[2];
    mn23 = (key_dist[3] < key_dist[2]) ? key_dist[3] : key_dist[2];
    mx   = (mx23 > mx01) ? mx23 : mx01;
    mn   = (mn23 < mn01) ? mn23 : mn01;
    // edge only when the window straddles the threshold
    if (mx >= threshold_level && mn < threshold_level) begin
      edge_value = mx - mn;
    end else begin
      edge_value = '0;
    end
  end

endmodule

@@ hdl/chroma_key_window_edge.sv @@
// Top level: position tracking, line buffer, window pipeline and output stage.
// A transfer passes stage 1, the stage 2 distance registers and the output register.
// Throughput: one pixel per cycle unless the output stalls; a last-column pixel gives
//   two results, sent in turn from the single output register.
// Line buffer: one read-first port, read and written at the same column per pixel.
// Reset clears counters, pipeline valids and config to defaults; RAM is not cleared.
module chroma_key_window_edge (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [23:0]                      s_tdata,   // comp_a, comp_b, comp_c
  input  logic                             s_tuser,   // start_of_frame
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata,   // edge_value, zero pad
  output logic                             m_tlast,   // last_of_run
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ckwe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ckwe_pkg::FW_W-1:0]        cfg_data
);

  localparam int AW = ckwe_pkg::ADDR_W;
  localparam int FW = ckwe_pkg::FW_W;

  logic [ckwe_pkg::COMP_W-1:0] target_first, target_second, target_third;
  logic [ckwe_pkg::DIST_W-1:0] threshold_level;
  logic [FW-1:0]               frame_width;

  logic [AW-1:0] column_count, column_count_next;
  logic          row_seen, row_seen_next;
  logic [AW-1:0] x;
  logic          rs_eff;
  logic [FW-1:0] width;
  logic          last_col;
  logic          accept;

  logic                         valid1;
  logic [ckwe_pkg::PIX_W-1:0]   px1;
  ckwe_pkg::win_ctl_t           ctl1, ctl2;
  logic [ckwe_pkg::PIX_W-1:0]   rd_px;
  logic [ckwe_pkg::PIX_W-1:0]   left_px, upl_px;
  logic                         valid2;
  logic [ckwe_pkg::DIST_W-1:0]  edge_val;

  logic                         out_valid, out_last, dup;
  logic [ckwe_pkg::DIST_W-1:0]  out_edge;

  logic out_can_take, s2_move, s1_move;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_first    <= '0;
      target_second   <= '0;
      target_third    <= '0;
      threshold_level <= ckwe_pkg::DIST_W'(128);
      frame_width     <= FW'(1920);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ckwe_pkg::REG_TARGET_FIRST:    target_first    <= cfg_data[ckwe_pkg::COMP_W-1:0];
        ckwe_pkg::REG_TARGET_SECOND:   target_second   <= cfg_data[ckwe_pkg::COMP_W-1:0];
        ckwe_pkg::REG_TARGET_THIRD:    target_third    <= cfg_data[ckwe_pkg::COMP_W-1:0];
        ckwe_pkg::REG_THRESHOLD_LEVEL: threshold_level <= cfg_data[ckwe_pkg::DIST_W-1:0];
        ckwe_pkg::REG_FRAME_WIDTH:     frame_width     <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake chain
  assign out_can_take = !out_valid || (m_tready && !dup);
  assign s2_move      = valid2 && (!ctl2.emit || out_can_take);
  assign s1_move      = valid1 && (!valid2 || s2_move);
  assign s_tready     = !valid1 || s1_move;
  assign accept       = s_tvalid && s_tready;

  // position of the incoming pixel
  always_comb begin
    logic [AW-1:0] x_raw;
    x_raw  = s_tuser ? '0 : column_count;
    rs_eff = s_tuser ? 1'b0 : row_seen;
    if ({1'b0, x_raw} >= (AW+1)'(ckwe_pkg::MAX_WIDTH)) begin
      x = AW'(ckwe_pkg::MAX_WIDTH - 1);
    end else begin
      x = x_raw;
    end
    if (frame_width < FW'(2)) begin
      width = FW'(2);
    end else if (frame_width > FW'(ckwe_pkg::MAX_WIDTH)) begin
      width = FW'(ckwe_pkg::MAX_WIDTH);
    end else begin
      width = frame_width;
    end
    last_col          = FW'(x) >= (width - FW'(1));
    column_count_next = last_col ? '0 : x + AW'(1);
    row_seen_next     = last_col ? 1'b1 : rs_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_seen     <= 1'b0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_seen     <= row_seen_next;
    end
  end

  ckwe_line_buf #(
    .DEPTH  (ckwe_pkg::MAX_WIDTH),
    .DATA_W (ckwe_pkg::PIX_W),
    .ADDR_W (AW)
  ) u_line_buf (
    .clk   (clk),
    .en    (accept),
    .we    (accept),
    .addr  (x),
    .wdata (s_tdata),
    .rdata (rd_px)
  );

  // stage 1: pixel waits for the line buffer read
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (accept) begin
      valid1 <= 1'b1;
    end else if (s1_move) begin
      valid1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px1       <= s_tdata;
      ctl1.emit <= rs_eff && (x != '0);
      ctl1.last <= last_col;
    end
  end

  // window neighbors shift as each pixel leaves stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      left_px <= '0;
      upl_px  <= '0;
    end else if (s1_move) begin
      left_px <= px1;
      upl_px  <= rd_px;
    end
  end

  // stage 2: distances registered
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (s1_move) begin
      valid2 <= 1'b1;
    end else if (s2_move) begin
      valid2 <= 1'b0;
    end
  end

  ckwe_edge_calc u_edge_calc (
    .clk             (clk),
    .load            (s1_move),
    .upl_px          (upl_px),
    .up_px           (rd_px),
    .left_px         (left_px),
    .cur_px          (px1),
    .target_first    (target_first),
    .target_second   (target_second),
    .target_third    (target_third),
    .threshold_level (threshold_level),
    .ctl_in          (ctl1),
    .ctl_out         (ctl2),
    .edge_value      (edge_val)
  );

  // output register; last column repeats the result with tlast set
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      dup       <= 1'b0;
    end else if (s2_move && ctl2.emit) begin
      out_valid <= 1'b1;
      out_last  <= !ctl2.last;
      dup       <= ctl2.last;
    end else if (out_valid && m_tready) begin
      if (dup) begin
        out_last <= 1'b1;
        dup      <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && ctl2.emit) begin
      out_edge <= edge_val;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(16 - ckwe_pkg::DIST_W)'(0), out_edge};
  assign m_tlast  = out_last;

endmodule

@@ hdl/ckwe_checker.sv @@
// Port-level assertions for the chroma key window edge block, bound to the top.
module ckwe_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // output is empty right after reset
  a_idle_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // a first copy is always followed by its repeat carrying tlast
  a_repeat_follows: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && m_tlast && m_tdata == $past(m_tdata)))
    else $error("last-column repeat missing or altered");

  // edge value stays in range with zero padding
  a_edge_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:10] == 6'd0 && m_tdata[9:0] <= 10'd765))
    else $error("edge value out of range");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output changed");

endmodule

bind chroma_key_window_edge ckwe_checker u_ckwe_checker (.*);

@@ test/tb.sv @@
// Self-checking testbench for the chroma key window edge block.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [9:0] strength;
    logic       last;
  } edge_result_t;

  typedef struct packed {
    logic       sof;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    int         want;   // -1: take the predicted value
  } pixel_row_t;

  localparam int NUM_PHASES = 12;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [ckwe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ckwe_pkg::FW_W-1:0]      cfg_data = '0;

  chroma_key_window_edge dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // predictor state and register shadow
  logic [7:0]  key_a, key_b, key_c;
  logic [9:0]  edge_thresh;
  logic [12:0] row_width;
  logic [23:0] line_mem [0:ckwe_pkg::MAX_WIDTH-1];
  logic [23:0] left_px, upleft_px;
  int          col_cnt;
  bit          row_open;

  edge_result_t edge_q[$];
  int  err_cnt = 0;
  int  send_idle = 0;
  int  recv_idle = 0;
  bit  calm = 1'b0;

  // directed rows, width 2, threshold 128, key color black
  pixel_row_t dir_tab [24] = '{
    '{1, 0, 0, 0, -1},       '{0, 255, 255, 255, -1}, '{0, 0, 0, 0, -1},
    '{0, 255, 255, 255, 765}, '{0, 128, 0, 0, -1},     '{0, 0, 0, 0, 765},
    '{0, 127, 0, 0, -1},     '{0, 0, 0, 0, 128},      '{0, 200, 0, 0, -1},
    '{0, 200, 0, 0, 200},    '{0, 200, 0, 0, -1},     '{0, 150, 100, 0, 0},
    '{0, 50, 0, 0, -1},      '{0, 60, 0, 0, 200},     '{0, 10, 0, 0, -1},
    '{0, 20, 0, 0, 0},       '{1, 0, 0, 0, -1},       '{0, 0, 0, 255, -1},
    '{0, 255, 0, 0, -1},     '{0, 0, 255, 0, 255},    '{1, 5, 5, 5, -1},
    '{0, 0, 0, 0, -1},       '{0, 255, 0, 0, -1},     '{0, 0, 0, 255, 255}
  };

  // per-phase settings, -1 picks a random value
  int ph_ta [NUM_PHASES] = '{-1, 255, -1, -1, -1, 0, -1, -1, -1, -1, -1, -1};
  int ph_tb [NUM_PHASES] = '{-1, 255, -1, -1, -1, 0, -1, -1, -1, -1, -1, -1};
  int ph_tc [NUM_PHASES] = '{-1, 255, -1, -1, -1, 0, -1, -1, -1, -1, -1, -1};
  int ph_thr[NUM_PHASES] = '{200, 766, 0, -1, -1, 1023, -1, -1, -1, -1, -1, -1};
  int ph_w  [NUM_PHASES] = '{0, 6, 3, 20, 5, 9, 13, 31, 4, 4096, 8191, 1};
  int ph_n  [NUM_PHASES] = '{120, 150, 120, 55, 150, 120, 200, 200, 300, 150, 100, 150};
  // phase 4 shrinks the width mid-row; phase 10 carries on the row with a width above the max
  bit ph_sof[NUM_PHASES] = '{1, 1, 1, 1, 0, 1, 1, 1, 1, 1, 0, 1};

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic int abs_delta(input logic [7:0] p, input logic [7:0] q);
    return (p > q) ? int'(p) - int'(q) : int'(q) - int'(p);
  endfunction

  function automatic int color_distance(input logic [23:0] px);
    return abs_delta(px[7:0], key_a) + abs_delta(px[15:8], key_b)
         + abs_delta(px[23:16], key_c);
  endfunction

  task automatic predict_window_edge(input bit sof, input logic [23:0] px,
                                     output int n, output int e);
    int w, x, mx, mn;
    int d [4];
    logic [23:0] up;
    bit last_col;
    if (sof) begin
      col_cnt = 0;
      row_open = 1'b0;
    end
    w = row_width;
    if (w < 2) w = 2;
    if (w > ckwe_pkg::MAX_WIDTH) w = ckwe_pkg::MAX_WIDTH;
    x = col_cnt;
    if (x >= ckwe_pkg::MAX_WIDTH) x = ckwe_pkg::MAX_WIDTH - 1;
    last_col = (x >= w - 1);
    up = line_mem[x];
    n = 0;
    e = 0;
    if (row_open && x >= 1) begin
      d[0] = color_distance(upleft_px);
      d[1] = color_distance(up);
      d[2] = color_distance(left_px);
      d[3] = color_distance(px);
      mx = d[0];
      mn = d[0];
      for (int i = 1; i < 4; i++) begin
        if (d[i] > mx) mx = d[i];
        if (d[i] < mn) mn = d[i];
      end
      if (mx >= edge_thresh && mn < edge_thresh) e = mx - mn;
      n = last_col ? 2 : 1;
    end
    line_mem[x] = px;
    upleft_px = up;
    left_px = px;
    if (last_col) begin
      col_cnt = 0;
      row_open = 1'b1;
    end else begin
      col_cnt = (x + 1) & 12'hFFF;
    end
  endtask

  task automatic send_pixel(input bit sof, input logic [23:0] px, input int want);
    int n, e;
    if ($urandom_range(0, 39) == 0) calm <= ~calm;
    while (!calm && $urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    s_tuser <= sof;
    do @(posedge clk); while (!s_tready);
    predict_window_edge(sof, px, n, e);
    if (want >= 0) e = want;
    if (n == 2) edge_q.push_back('{e[9:0], 1'b0});
    if (n >= 1) edge_q.push_back('{e[9:0], 1'b1});
  endtask

  task automatic write_reg(input ckwe_pkg::cfg_reg_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[ckwe_pkg::FW_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ckwe_pkg::REG_TARGET_FIRST:    key_a = val[7:0];
      ckwe_pkg::REG_TARGET_SECOND:   key_b = val[7:0];
      ckwe_pkg::REG_TARGET_THIRD:    key_c = val[7:0];
      ckwe_pkg::REG_THRESHOLD_LEVEL: edge_thresh = val[9:0];
      ckwe_pkg::REG_FRAME_WIDTH:     row_width = val[12:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int ta, input int tb, input int tc, input int thr,
                           input int w);
    write_reg(ckwe_pkg::REG_TARGET_FIRST, ta);
    write_reg(ckwe_pkg::REG_TARGET_SECOND, tb);
    write_reg(ckwe_pkg::REG_TARGET_THIRD, tc);
    write_reg(ckwe_pkg::REG_THRESHOLD_LEVEL, thr);
    write_reg(ckwe_pkg::REG_FRAME_WIDTH, w);
    cfg_valid <= 1'b0;
  endtask

  // pixels with no result may still be in flight once the queue runs dry
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_comp(input logic [7:0] key);
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 255;
      2, 3, 4, 5: begin
        v = int'(key) + $urandom_range(0, 80) - 40;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default: v = $urandom_range(0, 255);
    endcase
    return v[7:0];
  endfunction

  function automatic int pick_or(input int v, input int hi);
    return (v < 0) ? $urandom_range(0, hi) : v;
  endfunction

  // output side: check each transfer, then decide whether to stall
  always @(posedge clk) begin
    edge_result_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (edge_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d last %0b",
                                    m_tdata[9:0], m_tlast));
        end else begin
          exp_r = edge_q.pop_front();
          if (m_tdata !== {6'b0, exp_r.strength})
            report_mismatch($sformatf("edge value %0h, expected %0d",
                                      m_tdata, exp_r.strength));
          if (m_tlast !== exp_r.last)
            report_mismatch($sformatf("tlast %0b, expected %0b", m_tlast, exp_r.last));
        end
      end
      m_tready <= calm || ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin
    bit sof;
    int w;
    key_a = '0;
    key_b = '0;
    key_c = '0;
    edge_thresh = 10'd128;
    row_width = 13'd1920;
    left_px = '0;
    upleft_px = '0;
    col_cnt = 0;
    row_open = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle = 33;
    recv_idle = 84;
    write_all(0, 0, 0, 128, 2);
    foreach (dir_tab[i])
      send_pixel(dir_tab[i].sof, {dir_tab[i].c, dir_tab[i].b, dir_tab[i].a},
                 dir_tab[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_outputs();
      if (p == 4) begin
        send_idle = 84;
        recv_idle = 33;
      end else if (p == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_all(pick_or(ph_ta[p], 255), pick_or(ph_tb[p], 255), pick_or(ph_tc[p], 255),
                pick_or(ph_thr[p], 766), ph_w[p]);
      w = ph_w[p];
      for (int k = 0; k < ph_n[p]; k++) begin
        // stray frame starts only on narrow frames, where they cannot expose stale lines
        sof = (k == 0) ? ph_sof[p] : (w < 64 && $urandom_range(0, 79) == 0);
        send_pixel(sof, {pick_comp(key_c), pick_comp(key_b), pick_comp(key_a)}, -1);
      end
    end

    drain_outputs();
    repeat (12) @(posedge clk);
    while (edge_q.size() != 0) begin
      report_mismatch("expected result never arrived");
      edge_q.delete(0);
    end
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
